>>> rtl/core/srb_pkg.sv
// shared reorder buffer package: sizes, codes, flag and result word layouts
// no dependencies
`timescale 1ns / 1ps

package srb_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int ADDR_W  = 64;
  localparam int LEN_W   = 4;
  localparam int FLAGS_W = 16;

  typedef enum logic [1:0] {
    MODE_ALLOC,
    MODE_UPDATE,
    MODE_COMMIT,
    MODE_FLUSH_YOUNGER
  } mode_t;

  typedef enum logic [2:0] {
    KIND_ALLOCATED,
    KIND_FULL,
    KIND_UPDATED,
    KIND_RETIRED,
    KIND_HEAD_ARRIVED,
    KIND_FLUSHED,
    KIND_DONE
  } kind_t;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_EXCEPTION = 3'd1;
  localparam logic [2:0] EV_TRAP      = 3'd2;
  localparam logic [2:0] EV_SERIALIZE = 3'd4;

  localparam logic [1:0] ST_DEPS_READY = 2'd1;
  localparam logic [1:0] ST_COMPLETED  = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] ev;
    logic [7:0] code;
    logic       is_branch;
    logic       taken;
    logic       mispredicted;
  } flags_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [CNT_W-1:0]  slot;
    logic              owner;
    logic [2:0]        retire_event;
    logic [7:0]        event_code;
    logic [ADDR_W-1:0] inst_addr;
    logic [LEN_W-1:0]  inst_length;
    logic [ADDR_W-1:0] predictor_addr;
    logic [ADDR_W-1:0] predictor_target;
    logic              predictor_taken;
    logic              flush_thread;
    logic              last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_WALK,
    S_SEEK,
    S_FY_END,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/srb_if.sv
// valid/ready channel interfaces for the input and result words
// depends on srb_pkg
`timescale 1ns / 1ps

interface srb_in_if;
  import srb_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [IDX_W-1:0]  entry;
  logic              thread;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0]  length;
  logic [1:0]        status;
  logic [2:0]        event_req;
  logic [7:0]        code;
  logic              is_branch;
  logic              taken;
  logic              mispredicted;

  modport source (output valid, mode, entry, thread, addr, length, status, event_req, code,
                  is_branch, taken, mispredicted, input ready);
  modport sink (input valid, mode, entry, thread, addr, length, status, event_req, code,
                is_branch, taken, mispredicted, output ready);
endinterface

interface srb_out_if;
  import srb_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [CNT_W-1:0]  slot;
  logic              owner;
  logic [2:0]        retire_event;
  logic [7:0]        event_code;
  logic [ADDR_W-1:0] inst_addr;
  logic [LEN_W-1:0]  inst_length;
  logic [ADDR_W-1:0] predictor_addr;
  logic [ADDR_W-1:0] predictor_target;
  logic              predictor_taken;
  logic              flush_thread;
  logic              last;

  modport source (output valid, kind, slot, owner, retire_event, event_code, inst_addr,
                  inst_length, predictor_addr, predictor_target, predictor_taken,
                  flush_thread, last, input ready);
  modport sink (input valid, kind, slot, owner, retire_event, event_code, inst_addr,
                inst_length, predictor_addr, predictor_target, predictor_taken,
                flush_thread, last, output ready);
endinterface

>>> rtl/core/shared_reorder_buffer.sv
// shared reorder buffer top: linked order list, free chain and commit/flush walker
// depends on srb_pkg, srb_if and srb_ram
//
//   channel  dir  handshake    word
//   in_ch    in   valid/ready  mode, entry, thread, addr, length, status, event, flags
//   out_ch   out  valid/ready  kind, slot, owner, retire fields, predictor update, last
//
// allocate, update and bad-entry words are answered on acceptance; one word is taken at a time
// commit: accept, then per retired entry a head check and a payload ram read, then close with
// a check and the done word (plus an evaluation when the head is not completed); a thread flush
// walks every listed entry; flush younger: accept, seek from head to the entry, walk the younger
// entries when any, then the result
// results sit in an output register; a full output register holds the commit check and the
// closing word; reset is synchronous and builds the free chain at once
`timescale 1ns / 1ps

module shared_reorder_buffer (
  input logic      clk,
  input logic      rst_n,
  srb_in_if.sink   in_ch,
  srb_out_if.source out_ch
);
  import srb_pkg::*;

  state_t           state_r, state_nxt;
  logic [ENTRIES-1:0] in_use_r, in_use_nxt;
  logic [IDX_W-1:0] link_r [ENTRIES];
  logic [IDX_W-1:0] link_nxt [ENTRIES];
  logic             thread_r [ENTRIES];
  logic [IDX_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [IDX_W-1:0] fhead_r, fhead_nxt, ftail_r, ftail_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt, fy_ent_r, fy_ent_nxt;
  logic             hp_r, hp_nxt, wt_r, wt_nxt, wcommit_r, wcommit_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt, pos_r, pos_nxt, removed_r, removed_nxt;
  result_t          out_r, res;
  logic             out_valid_r, load;

  logic             out_free, acc;
  logic [IDX_W-1:0] lk_addr, th_addr, lk_q;
  logic             th_q;
  logic             thr_we;
  logic [IDX_W-1:0] thr_waddr;
  logic             rel_en, rel_hp;
  logic [IDX_W-1:0] rel_cur, rel_prev, rel_nx;

  logic                    a_we, b_we;
  logic [IDX_W-1:0]        a_waddr, b_waddr;
  logic [ADDR_W+LEN_W-1:0] a_wdata, a_q;
  logic [ADDR_W+FLAGS_W-1:0] b_wdata, b_q;
  flags_t            f, upd_f;
  logic [ADDR_W-1:0] e_addr, e_tgt;
  logic [LEN_W-1:0]  e_len;
  logic              fl;

  srb_ram #(.WIDTH(ADDR_W + LEN_W), .DEPTH(ENTRIES)) u_addr_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(head_r), .rdata(a_q)
  );

  srb_ram #(.WIDTH(ADDR_W + FLAGS_W), .DEPTH(ENTRIES)) u_flag_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(head_r), .rdata(b_q)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign acc = in_ch.valid && in_ch.ready;

  assign lk_q = link_r[lk_addr];
  assign th_q = thread_r[th_addr];
  assign rel_nx = link_r[rel_cur];

  assign f      = flags_t'(b_q[FLAGS_W-1:0]);
  assign e_tgt  = b_q[ADDR_W+FLAGS_W-1:FLAGS_W];
  assign e_addr = a_q[ADDR_W+LEN_W-1:LEN_W];
  assign e_len  = a_q[LEN_W-1:0];
  assign fl     = (f.ev != EV_NONE) || f.mispredicted;

  always_comb begin
    upd_f.status       = in_ch.status;
    upd_f.ev           = (in_ch.event_req > EV_SERIALIZE) ? EV_NONE : in_ch.event_req;
    upd_f.code         = in_ch.code;
    upd_f.is_branch    = in_ch.is_branch;
    upd_f.taken        = in_ch.taken;
    upd_f.mispredicted = in_ch.mispredicted;
  end

  always_comb begin
    state_nxt   = state_r;
    in_use_nxt  = in_use_r;
    link_nxt    = link_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fhead_nxt   = fhead_r;
    ftail_nxt   = ftail_r;
    occ_nxt     = occ_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    hp_nxt      = hp_r;
    wt_nxt      = wt_r;
    wcommit_nxt = wcommit_r;
    steps_nxt   = steps_r;
    pos_nxt     = pos_r;
    removed_nxt = removed_r;
    fy_ent_nxt  = fy_ent_r;
    res         = '0;
    load        = 1'b0;
    thr_we      = 1'b0;
    thr_waddr   = fhead_r;
    a_we        = 1'b0;
    a_waddr     = fhead_r;
    a_wdata     = {in_ch.addr, in_ch.length};
    b_we        = 1'b0;
    b_waddr     = fhead_r;
    b_wdata     = '0;
    rel_en      = 1'b0;
    rel_cur     = cur_r;
    rel_hp      = hp_r;
    rel_prev    = prev_r;
    lk_addr     = cur_r;
    th_addr     = cur_r;

    case (state_r)
      S_IDLE: begin
        lk_addr = fhead_r;
        th_addr = in_ch.entry;
        if (acc) begin
          case (mode_t'(in_ch.mode))
            MODE_ALLOC: begin
              load = 1'b1;
              res.last = 1'b1;
              if (occ_r >= CNT_W'(ENTRIES)) begin
                res.kind = KIND_FULL;
                res.slot = occ_r;
              end else begin
                fhead_nxt = lk_q;
                in_use_nxt[fhead_r] = 1'b1;
                thr_we = 1'b1;
                a_we = 1'b1;
                b_we = 1'b1;
                if (occ_r == '0) begin
                  head_nxt = fhead_r;
                end else begin
                  link_nxt[tail_r] = fhead_r;
                end
                tail_nxt = fhead_r;
                occ_nxt = occ_r + CNT_W'(1);
                res.kind = KIND_ALLOCATED;
                res.slot = {1'b0, fhead_r};
                res.owner = in_ch.thread;
              end
            end
            MODE_UPDATE: begin
              load = 1'b1;
              res.last = 1'b1;
              if (in_use_r[in_ch.entry]) begin
                b_we = 1'b1;
                b_waddr = in_ch.entry;
                b_wdata = {in_ch.addr, upd_f};
                res.kind = KIND_UPDATED;
                res.slot = {1'b0, in_ch.entry};
                res.owner = th_q;
              end else begin
                res.kind = KIND_DONE;
                res.slot = occ_r;
              end
            end
            MODE_FLUSH_YOUNGER: begin
              if (in_use_r[in_ch.entry]) begin
                fy_ent_nxt = in_ch.entry;
                wt_nxt = th_q;
                cur_nxt = head_r;
                pos_nxt = '0;
                state_nxt = S_SEEK;
              end else begin
                load = 1'b1;
                res.kind = KIND_FLUSHED;
                res.last = 1'b1;
              end
            end
            default: begin
              state_nxt = S_CHECK;
            end
          endcase
        end
      end
      S_CHECK: begin
        state_nxt = (occ_r == '0) ? S_DONE : S_EVAL;
      end
      S_EVAL: begin
        th_addr = head_r;
        if (out_free) begin
          if (f.status != ST_COMPLETED) begin
            if (f.status == ST_DEPS_READY) begin
              load = 1'b1;
              res.kind = KIND_HEAD_ARRIVED;
              res.slot = {1'b0, head_r};
              res.owner = th_q;
            end
            state_nxt = S_DONE;
          end else begin
            load = 1'b1;
            res.kind = KIND_RETIRED;
            res.slot = {1'b0, head_r};
            res.owner = th_q;
            res.retire_event = f.ev;
            res.event_code = (f.ev == EV_EXCEPTION || f.ev == EV_TRAP) ? f.code : 8'd0;
            res.inst_addr = e_addr;
            res.inst_length = e_len;
            if (f.ev == EV_NONE && f.is_branch) begin
              res.predictor_addr = e_addr + {{(ADDR_W-LEN_W){1'b0}}, e_len} - ADDR_W'(1);
              res.predictor_target = e_tgt;
              res.predictor_taken = f.taken;
            end
            res.flush_thread = fl;
            if (fl) begin
              cur_nxt = head_r;
              hp_nxt = 1'b0;
              steps_nxt = occ_r;
              wt_nxt = th_q;
              wcommit_nxt = 1'b1;
              removed_nxt = '0;
              state_nxt = S_WALK;
            end else begin
              rel_en = 1'b1;
              rel_cur = head_r;
              rel_hp = 1'b0;
              state_nxt = S_CHECK;
            end
          end
        end
      end
      S_WALK: begin
        if (steps_r == '0) begin
          state_nxt = wcommit_r ? S_DONE : S_FY_END;
        end else begin
          if (th_q == wt_r) begin
            rel_en = 1'b1;
            removed_nxt = removed_r + CNT_W'(1);
          end else begin
            hp_nxt = 1'b1;
            prev_nxt = cur_r;
          end
          cur_nxt = lk_q;
          steps_nxt = steps_r - CNT_W'(1);
        end
      end
      S_SEEK: begin
        cur_nxt = lk_q;
        if (cur_r == fy_ent_r) begin
          removed_nxt = '0;
          if (pos_r + CNT_W'(1) < occ_r) begin
            prev_nxt = cur_r;
            hp_nxt = 1'b1;
            steps_nxt = occ_r - pos_r - CNT_W'(1);
            wcommit_nxt = 1'b0;
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_FY_END;
          end
        end else begin
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
      S_FY_END: begin
        if (out_free) begin
          load = 1'b1;
          res.kind = KIND_FLUSHED;
          res.slot = removed_r;
          res.owner = wt_r;
          res.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load = 1'b1;
          res.kind = KIND_DONE;
          res.slot = occ_r;
          res.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // unlink an entry and append it to the free chain
    if (rel_en) begin
      if (!rel_hp) begin
        head_nxt = rel_nx;
      end else begin
        link_nxt[rel_prev] = rel_nx;
      end
      if (rel_cur == tail_r && rel_hp) begin
        tail_nxt = rel_prev;
      end
      if (occ_r >= CNT_W'(ENTRIES)) begin
        fhead_nxt = rel_cur;
      end else begin
        link_nxt[ftail_r] = rel_cur;
      end
      ftail_nxt = rel_cur;
      in_use_nxt[rel_cur] = 1'b0;
      occ_nxt = occ_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fhead_r     <= '0;
      ftail_r     <= IDX_W'(ENTRIES - 1);
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        link_r[i] <= IDX_W'((i + 1) % ENTRIES);
      end
    end else begin
      state_r  <= state_nxt;
      in_use_r <= in_use_nxt;
      link_r   <= link_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fhead_r  <= fhead_nxt;
      ftail_r  <= ftail_nxt;
      occ_r    <= occ_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    hp_r      <= hp_nxt;
    wt_r      <= wt_nxt;
    wcommit_r <= wcommit_nxt;
    steps_r   <= steps_nxt;
    pos_r     <= pos_nxt;
    removed_r <= removed_nxt;
    fy_ent_r  <= fy_ent_nxt;
    if (load) begin
      out_r <= res;
    end
    if (thr_we) begin
      thread_r[thr_waddr] <= in_ch.thread;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = out_r.kind;
  assign out_ch.slot             = out_r.slot;
  assign out_ch.owner            = out_r.owner;
  assign out_ch.retire_event     = out_r.retire_event;
  assign out_ch.event_code       = out_r.event_code;
  assign out_ch.inst_addr        = out_r.inst_addr;
  assign out_ch.inst_length      = out_r.inst_length;
  assign out_ch.predictor_addr   = out_r.predictor_addr;
  assign out_ch.predictor_target = out_r.predictor_target;
  assign out_ch.predictor_taken  = out_r.predictor_taken;
  assign out_ch.flush_thread     = out_r.flush_thread;
  assign out_ch.last             = out_r.last;

endmodule

>>> rtl/core/srb_ram.sv
// simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
